// ===== rtl/three_level_priority_queue_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the three-level priority queue
// Checks are compiled for simulation only; synthesis sees empty macros.
// ----------------------------------------------------------------------------
`ifndef THREE_LEVEL_PRIORITY_QUEUE_ASSERT_SVH
`define THREE_LEVEL_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset
`define TPQ_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tpq assertion failed");
// Expression must never be true outside reset
`define TPQ_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("tpq forbidden condition seen");
`else
`define TPQ_ASSERT(label, clk, rst_n, prop)
`define TPQ_ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

// ===== rtl/tpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared types and codes of the three-level priority queue.
// ----------------------------------------------------------------------------
package tpq_pkg;

  localparam int unsigned NUM_Q = 3;

  // Operation codes of an input transaction
  localparam logic [1:0] MODE_ENQ   = 2'd0;
  localparam logic [1:0] MODE_DEQ   = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Enqueue priority codes (anything else goes low)
  localparam logic [1:0] LEVEL_HIGH = 2'd1;
  localparam logic [1:0] LEVEL_MID  = 2'd2;

  // Queue indexes
  localparam logic [1:0] Q_HIGH = 2'd0;
  localparam logic [1:0] Q_MID  = 2'd1;
  localparam logic [1:0] Q_LOW  = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // Byte returned when nothing is dequeued ('?')
  localparam logic [7:0] EMPTY_CHAR = 8'd63;

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic latch_in;
    logic exec;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

// ===== rtl/three_level_priority_queue.sv =====
// The input transaction is latched, executed into the result registers and
// loaded into the output register; the load waits while the output is busy.
// No new item is taken until the last one is loaded into the output register.
// A new item is taken while a finished result still waits on the output.
// Reset (rst_ni low, asynchronous) empties all three queues and the output.
// ----------------------------------------------------------------------------
// three_level_priority_queue
// Three byte FIFOs served in strict priority: enqueue by level, dequeue from
// the highest non-empty FIFO, clear empties all.
// ----------------------------------------------------------------------------
module three_level_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // mode[1:0], level[3:2], data_in[11:4]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // data_out[7:0], served_level[9:8], status[11:10]
);

  tpq_pkg::cmd_t cmd;
  tpq_pkg::sts_t sts;

  tpq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  tpq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_tdata_i  (s_axis_tdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_tdata_o (m_axis_tdata_o)
  );

endmodule

// ===== rtl/tpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpq_ctrl
// Sequencer: accept one transaction, execute it, hand the result to the
// output register.
// ----------------------------------------------------------------------------
`include "three_level_priority_queue_assert.svh"

module tpq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  output logic           s_ready_o,
  input  tpq_pkg::sts_t  sts_i,
  output tpq_pkg::cmd_t  cmd_o
);

  tpq_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    s_ready_o      = 1'b0;
    unique case (state_q)
      tpq_pkg::ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = tpq_pkg::ST_EXEC;
        end
      end
      tpq_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = tpq_pkg::ST_LOAD;
      end
      tpq_pkg::ST_LOAD: begin
        // Hold until the output register is free
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = tpq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tpq_pkg::ST_IDLE;
      end
    endcase
  end

  `TPQ_ASSERT(a_exec_after_latch, clk_i, rst_ni, cmd_o.exec |-> $past(cmd_o.latch_in))
  `TPQ_ASSERT_NEVER(a_load_when_busy, clk_i, rst_ni, cmd_o.load_out && sts_i.out_busy)
  `TPQ_ASSERT(a_latch_then_exec, clk_i, rst_ni, cmd_o.latch_in |=> cmd_o.exec)

endmodule

// ===== rtl/tpq_dpath.sv =====
// ----------------------------------------------------------------------------
// tpq_dpath
// Queue storage, per-queue pointers and counts, result and output registers.
// ----------------------------------------------------------------------------
`include "three_level_priority_queue_assert.svh"

module tpq_dpath #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tpq_pkg::cmd_t                       cmd_i,
  output tpq_pkg::sts_t                       sts_o,
  input  logic [tpq_pkg::IN_TDATA_W-1:0]      in_tdata_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [tpq_pkg::OUT_TDATA_W-1:0]     out_tdata_o
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AW = $clog2(3 * QUEUE_DEPTH);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] BASE_MID = AW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] BASE_LOW = AW'(2 * QUEUE_DEPTH);

  // Latched input transaction
  logic [1:0] mode_q;
  logic [1:0] level_q;
  logic [7:0] byte_q;

  // Queue state
  logic [7:0]    mem [3*QUEUE_DEPTH];
  logic [PW-1:0] head_q  [tpq_pkg::NUM_Q];
  logic [PW-1:0] tail_q  [tpq_pkg::NUM_Q];
  logic [CW-1:0] count_q [tpq_pkg::NUM_Q];

  // Result of the executed transaction
  logic [7:0] rd_data_q;
  logic [1:0] res_served_q;
  logic [1:0] res_status_q;
  logic       res_use_mem_q;

  // Output register
  logic       out_valid_q;
  logic [7:0] out_data_q;
  logic [1:0] out_served_q;
  logic [1:0] out_status_q;

  logic [1:0]    enq_q_sel;
  logic [1:0]    deq_q_sel;
  logic          deq_any;
  logic [1:0]    sel;
  logic          is_enq;
  logic          is_deq;
  logic          is_clear;
  logic          sel_full;
  logic          do_write;
  logic          do_read;
  logic [PW-1:0] sel_ptr;
  logic [PW-1:0] sel_ptr_next;
  logic [AW-1:0] base;
  logic [AW-1:0] addr;

  // Capture the accepted transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      mode_q  <= in_tdata_i[1:0];
      level_q <= in_tdata_i[3:2];
      byte_q  <= in_tdata_i[11:4];
    end
  end

  // Decode target queue and priority pick
  always_comb begin
    is_enq   = (mode_q == tpq_pkg::MODE_ENQ);
    is_deq   = (mode_q == tpq_pkg::MODE_DEQ);
    is_clear = (mode_q == tpq_pkg::MODE_CLEAR);

    if (level_q == tpq_pkg::LEVEL_HIGH) begin
      enq_q_sel = tpq_pkg::Q_HIGH;
    end else if (level_q == tpq_pkg::LEVEL_MID) begin
      enq_q_sel = tpq_pkg::Q_MID;
    end else begin
      enq_q_sel = tpq_pkg::Q_LOW;
    end

    deq_any = 1'b1;
    priority if (count_q[0] != '0) begin
      deq_q_sel = tpq_pkg::Q_HIGH;
    end else if (count_q[1] != '0) begin
      deq_q_sel = tpq_pkg::Q_MID;
    end else if (count_q[2] != '0) begin
      deq_q_sel = tpq_pkg::Q_LOW;
    end else begin
      deq_q_sel = tpq_pkg::Q_HIGH;
      deq_any   = 1'b0;
    end

    sel      = is_enq ? enq_q_sel : deq_q_sel;
    sel_full = (count_q[sel] == CNT_FULL);
    do_write = cmd_i.exec && is_enq && !sel_full;
    do_read  = cmd_i.exec && is_deq && deq_any;

    sel_ptr      = is_enq ? tail_q[sel] : head_q[sel];
    sel_ptr_next = (sel_ptr == PTR_LAST) ? '0 : sel_ptr + 1'b1;

    unique case (sel)
      tpq_pkg::Q_MID: base = BASE_MID;
      tpq_pkg::Q_LOW: base = BASE_LOW;
      default:        base = '0;
    endcase
    addr = base + AW'(sel_ptr);
  end

  // Storage write and registered read
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem[addr] <= byte_q;
    end
    if (do_read) begin
      rd_data_q <= mem[addr];
    end
  end

  // Advance pointers and counts; clear empties all queues
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tpq_pkg::NUM_Q; i++) begin
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else if (cmd_i.exec && is_clear) begin
      for (int i = 0; i < tpq_pkg::NUM_Q; i++) begin
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else if (do_write) begin
      tail_q[sel]  <= sel_ptr_next;
      count_q[sel] <= count_q[sel] + 1'b1;
    end else if (do_read) begin
      head_q[sel]  <= sel_ptr_next;
      count_q[sel] <= count_q[sel] - 1'b1;
    end
  end

  // Record result fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_use_mem_q <= is_deq && deq_any;
      res_served_q  <= (is_enq || (is_deq && deq_any)) ? sel : tpq_pkg::Q_HIGH;
      if (is_enq && sel_full) begin
        res_status_q <= tpq_pkg::STATUS_FULL;
      end else if (is_deq && !deq_any) begin
        res_status_q <= tpq_pkg::STATUS_EMPTY;
      end else begin
        res_status_q <= tpq_pkg::STATUS_OK;
      end
    end
  end

  // Output register: load on command, drop on transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q   <= res_use_mem_q ? rd_data_q : tpq_pkg::EMPTY_CHAR;
      out_served_q <= res_served_q;
      out_status_q <= res_status_q;
    end
  end

  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_tdata_o    = {4'b0, out_status_q, out_served_q, out_data_q};

  `TPQ_ASSERT_NEVER(a_count_range, clk_i, rst_ni,
    (count_q[0] > CNT_FULL) || (count_q[1] > CNT_FULL) || (count_q[2] > CNT_FULL))
  `TPQ_ASSERT(a_clear_empties, clk_i, rst_ni,
    (cmd_i.exec && is_clear) |=> (count_q[0] == '0 && count_q[1] == '0 && count_q[2] == '0))
  `TPQ_ASSERT(a_valid_from_load, clk_i, rst_ni, $rose(out_valid_q) |-> $past(cmd_i.load_out))
  `TPQ_ASSERT_NEVER(a_rw_exclusive, clk_i, rst_ni, do_write && do_read)

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench of the three-level priority queue
// Streams enqueue, dequeue, clear and unused-mode transactions into the block.
// Each accepted transaction runs through a behavioral copy of the three
// FIFOs. Every output transaction is compared field by field with the oldest
// predicted result. Input and output idle at random in the first two of three
// pressure phases; the last phase runs with no idling.
module testbench;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_WAIT  = 12;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] level;
    logic [7:0] data;
  } queue_op_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic [1:0] served_level;
    logic [1:0] status;
  } queue_reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // mode[1:0], level[3:2], data_in[11:4]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // data_out[7:0], served_level[9:8], status[11:10]

  // Stimulus and scoreboard storage
  queue_op_t    pending_ops[$];
  queue_reply_t expected_replies[$];
  queue_op_t    held_op;
  logic [7:0]   level_fifo[tpq_pkg::NUM_Q][$];

  int unsigned ops_total;
  int unsigned ops_loaded;
  int unsigned ops_accepted;
  int unsigned counted_ops;
  int unsigned replies_seen;
  int unsigned mismatches;
  int unsigned full_drops;
  int unsigned empty_pops;
  int unsigned clears_done;
  int unsigned stall_phase;
  int unsigned quiet_cycles;

  three_level_priority_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata)
  );

  // Clock generation
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Update the FIFO copies for one transaction and return its reply
  function automatic queue_reply_t serve_op(queue_op_t op);
    queue_reply_t reply;
    logic [1:0]   q;
    reply = '{data_out: tpq_pkg::EMPTY_CHAR, served_level: tpq_pkg::Q_HIGH,
              status: tpq_pkg::STATUS_OK};
    case (op.mode)
      tpq_pkg::MODE_ENQ: begin
        if (op.level == tpq_pkg::LEVEL_HIGH) q = tpq_pkg::Q_HIGH;
        else if (op.level == tpq_pkg::LEVEL_MID) q = tpq_pkg::Q_MID;
        else q = tpq_pkg::Q_LOW;
        reply.served_level = q;
        if (level_fifo[q].size() >= DEPTH) begin
          reply.status = tpq_pkg::STATUS_FULL;
          full_drops++;
        end else begin
          level_fifo[q].push_back(op.data);
        end
      end
      tpq_pkg::MODE_DEQ: begin
        if (level_fifo[tpq_pkg::Q_HIGH].size() != 0) q = tpq_pkg::Q_HIGH;
        else if (level_fifo[tpq_pkg::Q_MID].size() != 0) q = tpq_pkg::Q_MID;
        else q = tpq_pkg::Q_LOW;
        if (level_fifo[q].size() == 0) begin
          reply.status = tpq_pkg::STATUS_EMPTY;
          empty_pops++;
        end else begin
          reply.data_out     = level_fifo[q].pop_front();
          reply.served_level = q;
        end
      end
      tpq_pkg::MODE_CLEAR: begin
        for (int i = 0; i < tpq_pkg::NUM_Q; i++) level_fifo[i].delete();
        clears_done++;
      end
      default: ;
    endcase
    return reply;
  endfunction

  task automatic add_op(logic [1:0] mode, logic [1:0] level, logic [7:0] data);
    pending_ops.push_back('{mode: mode, level: level, data: data});
    if (mode != MODE_UNUSED) counted_ops++;
  endtask

  // Input side: hold an offered transaction until accepted, idle per phase
  always @(posedge clk_i or negedge rst_ni) begin : op_driver
    int unsigned idle_pct;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_replies.push_back(serve_op(held_op));
        ops_accepted++;
      end
      idle_pct = (stall_phase == 0) ? 22 : (stall_phase == 1) ? 86 : 0;
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= idle_pct) begin
          held_op = pending_ops.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'b0, held_op.data, held_op.level, held_op.mode};
          ops_loaded++;
          stall_phase <= (ops_loaded * 3) / ops_total;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side: compare each accepted reply, stall per phase
  always @(posedge clk_i or negedge rst_ni) begin : reply_monitor
    queue_reply_t got;
    queue_reply_t want;
    int unsigned  idle_pct;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{data_out: m_axis_tdata[7:0], served_level: m_axis_tdata[9:8],
                status: m_axis_tdata[11:10]};
        replies_seen++;
        if (expected_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected reply data=%02h level=%0d status=%0d",
                     got.data_out, got.served_level, got.status);
        end else begin
          want = expected_replies.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: reply %0d expected data=%02h level=%0d status=%0d,",
                       replies_seen, want.data_out, want.served_level, want.status,
                       " got data=%02h level=%0d status=%0d",
                       got.data_out, got.served_level, got.status);
          end
        end
      end
      idle_pct = (stall_phase == 0) ? 86 : (stall_phase == 1) ? 22 : 0;
      m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("ERROR: no transaction for %0d cycles", quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus, reset and end of run
  initial begin : stimulus
    int unsigned n;
    int unsigned pick;
    logic [1:0]  lvl;
    int unsigned directed_ops;

    // Directed: every level code, data extremes, unused mode, priority order
    add_op(tpq_pkg::MODE_ENQ, 2'd0, 8'h00);
    add_op(tpq_pkg::MODE_ENQ, 2'd3, 8'hFF);
    add_op(tpq_pkg::MODE_ENQ, tpq_pkg::LEVEL_MID, 8'h80);
    add_op(tpq_pkg::MODE_ENQ, tpq_pkg::LEVEL_HIGH, 8'h7F);
    add_op(MODE_UNUSED, 2'd3, 8'hFF);
    repeat (4) add_op(tpq_pkg::MODE_DEQ, 2'd0, 8'h00);
    add_op(tpq_pkg::MODE_DEQ, 2'd3, 8'hFF);
    // Fill the high queue past its depth, then clear and pop from empty
    for (int i = 0; i <= DEPTH; i++) add_op(tpq_pkg::MODE_ENQ, tpq_pkg::LEVEL_HIGH, 8'(i * 17));
    add_op(tpq_pkg::MODE_CLEAR, 2'd0, 8'h00);
    add_op(tpq_pkg::MODE_DEQ, 2'd0, 8'h00);
    directed_ops = counted_ops;

    // Random: bursts that fill and drain queues, plus mixed traffic
    while (counted_ops < directed_ops + RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        lvl = 2'($urandom_range(3));
        n = $urandom_range(20, 1);
        repeat (n) add_op(tpq_pkg::MODE_ENQ, lvl, 8'($urandom_range(255)));
      end else if (pick < 55) begin
        n = $urandom_range(24, 1);
        repeat (n)
          add_op(tpq_pkg::MODE_DEQ, 2'($urandom_range(3)), 8'($urandom_range(255)));
      end else if (pick < 59) begin
        add_op(tpq_pkg::MODE_CLEAR, 2'($urandom_range(3)), 8'($urandom_range(255)));
      end else begin
        n = $urandom_range(16, 1);
        repeat (n) begin
          pick = $urandom_range(99);
          if (pick < 45)
            add_op(tpq_pkg::MODE_ENQ, 2'($urandom_range(3)), 8'($urandom_range(255)));
          else if (pick < 90)
            add_op(tpq_pkg::MODE_DEQ, 2'($urandom_range(3)), 8'($urandom_range(255)));
          else if (pick < 95)
            add_op(tpq_pkg::MODE_CLEAR, 2'($urandom_range(3)), 8'($urandom_range(255)));
          else
            add_op(MODE_UNUSED, 2'($urandom_range(3)), 8'($urandom_range(255)));
        end
      end
    end
    ops_total = pending_ops.size();

    // Hold reset, then release it
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every transaction to be accepted and answered
    while (ops_accepted < ops_total || expected_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Ran %0d transactions, %0d replies checked, %0d mismatches.",
             ops_total, replies_seen, mismatches);
    $display("Saw %0d full-queue drops, %0d empty dequeues and %0d clears.",
             full_drops, empty_pops, clears_done);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
